// ===== hdl/pcb_pkg.sv =====
// Shared types, constants and helper functions of the particle cell binning sampler.
// Depends on nothing; all files but pcb_fifo and pcb_checker import it.
`timescale 1ns / 1ps
`default_nettype none

package pcb_pkg;

    // default grid and list geometry
    localparam int DEF_CELLS_X    = 16;
    localparam int DEF_CELLS_Y    = 16;
    localparam int DEF_CELLS_Z    = 8;
    localparam int DEF_LIST_DEPTH = 32;

    // widths fixed by the item fields
    localparam int CELL_IDX_W = 24;   // holds any cell index below 256^3
    localparam int V2_W       = 41;   // sum of three 20-bit squares
    localparam int CFG_IDX_W  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INV_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_Z = 2'd2;

    localparam logic [31:0] INV_RESET = 32'd65536;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_BIN   = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    // classified item handed from front to back
    typedef struct packed {
        mode_t                  mode;
        logic [CELL_IDX_W-1:0]  cell_idx;
        logic [10:0]            cell_number;
        logic                   in_grid;
        logic [4:0]             slot;
        logic [15:0]            id;
        logic signed [19:0]     vel_x;
        logic signed [19:0]     vel_y;
        logic signed [19:0]     vel_z;
        logic [V2_W-1:0]        v2;
        logic                   sample_enable;
    } cmd_t;

    // per-cell moments
    typedef struct packed {
        logic [31:0]        count;
        logic signed [63:0] vx;
        logic signed [63:0] vy;
        logic signed [63:0] vz;
        logic [63:0]        v2;
    } mom_t;

    // one result beat
    typedef struct packed {
        logic [10:0]        cell_number;
        logic [4:0]         slot;
        logic               overflow;
        logic [5:0]         cell_count;
        logic [15:0]        list_entry;
        logic [31:0]        sample_count;
        logic signed [63:0] sum_vx;
        logic signed [63:0] sum_vy;
        logic signed [63:0] sum_vz;
        logic [63:0]        sum_v2;
        logic [31:0]        sample_steps;
    } res_t;

    // truncate scaled coordinate toward zero and clamp to the grid
    function automatic logic [7:0] axis_idx(input logic signed [64:0] p, input int cells);
        logic [31:0] hi;
        begin
            hi = p[63:32];
            if (p[64])
                axis_idx = '0;
            else if (hi >= 32'(cells))
                axis_idx = 8'(cells - 1);
            else
                axis_idx = 8'(hi);
        end
    endfunction

    function automatic logic signed [63:0] sat_add_s(input logic signed [63:0] a,
                                                     input logic signed [19:0] b);
        logic signed [63:0] bx;
        logic signed [63:0] s;
        begin
            bx = {{44{b[19]}}, b};
            s  = a + bx;
            if ((a[63] == bx[63]) && (s[63] != a[63]))
                sat_add_s = bx[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            else
                sat_add_s = s;
        end
    endfunction

    function automatic logic [63:0] sat_add_u(input logic [63:0] a, input logic [V2_W-1:0] b);
        logic [64:0] s;
        begin
            s = {1'b0, a} + 65'(b);
            sat_add_u = s[64] ? {64{1'b1}} : s[63:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/pcb_fifo.sv =====
// Small register queue used between front and back and on the result side.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module pcb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

// ===== hdl/pcb_front.sv =====
// Front end: accepts item beats, holds the cell-size registers and classifies
// each item into a cell. Depends on pcb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcb_front import pcb_pkg::*; #(
    parameter int CELLS_X = DEF_CELLS_X,
    parameter int CELLS_Y = DEF_CELLS_Y,
    parameter int CELLS_Z = DEF_CELLS_Z
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [1:0]           mode,
    input  wire logic signed [31:0]   pos_x,
    input  wire logic signed [31:0]   pos_y,
    input  wire logic signed [31:0]   pos_z,
    input  wire logic signed [19:0]   vel_x,
    input  wire logic signed [19:0]   vel_y,
    input  wire logic signed [19:0]   vel_z,
    input  wire logic [15:0]          particle_id,
    input  wire logic                 sample_enable,
    input  wire logic [10:0]          read_cell,
    input  wire logic [4:0]           read_slot,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire logic                 init_busy,
    input  wire logic                 q_full,
    output logic                      q_push,
    output cmd_t                      q_din
);

    localparam int NCELLS = CELLS_X * CELLS_Y * CELLS_Z;

    typedef struct packed {
        mode_t              mode;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [19:0] vel_x;
        logic signed [19:0] vel_y;
        logic signed [19:0] vel_z;
        logic [15:0]        id;
        logic               sample_enable;
        logic [10:0]        read_cell;
        logic [4:0]         read_slot;
    } item_t;

    logic [31:0]        inv_x_reg, inv_y_reg, inv_z_reg;
    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg;
    item_t              s1_reg, s2_reg;
    logic signed [64:0] px_reg, py_reg, pz_reg;
    logic [39:0]        sqx_reg, sqy_reg, sqz_reg;
    cmd_t               cmd_reg, cmd_next;
    logic               adv, accept;
    logic signed [64:0] px_next, py_next, pz_next;
    logic signed [39:0] sqx_next, sqy_next, sqz_next;
    logic [7:0]         ix, iy, iz;
    logic [CELL_IDX_W-1:0] bin_cell;

    // whole pipe moves unless the classified beat cannot enter the queue
    assign adv    = !(s3_valid_reg && q_full);
    assign full   = !adv || init_busy;
    assign accept = push && !full;
    assign q_push = s3_valid_reg && !q_full;
    assign q_din  = cmd_reg;

    // cell-size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_x_reg <= INV_RESET;
            inv_y_reg <= INV_RESET;
            inv_z_reg <= INV_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_INV_X)
                inv_x_reg <= cfg_data;
            else if (cfg_index == CFG_INV_Y)
                inv_y_reg <= cfg_data;
            else if (cfg_index == CFG_INV_Z)
                inv_z_reg <= cfg_data;
        end
    end

    // scale positions and square velocities
    always_comb
    begin
        px_next  = s1_reg.pos_x * signed'({1'b0, inv_x_reg});
        py_next  = s1_reg.pos_y * signed'({1'b0, inv_y_reg});
        pz_next  = s1_reg.pos_z * signed'({1'b0, inv_z_reg});
        sqx_next = s1_reg.vel_x * s1_reg.vel_x;
        sqy_next = s1_reg.vel_y * s1_reg.vel_y;
        sqz_next = s1_reg.vel_z * s1_reg.vel_z;
    end

    // clamp to grid and form the linear cell
    always_comb
    begin
        ix       = axis_idx(px_reg, CELLS_X);
        iy       = axis_idx(py_reg, CELLS_Y);
        iz       = axis_idx(pz_reg, CELLS_Z);
        bin_cell = (CELL_IDX_W'(ix) * CELL_IDX_W'(CELLS_Y) + CELL_IDX_W'(iy))
                   * CELL_IDX_W'(CELLS_Z) + CELL_IDX_W'(iz);
        cmd_next.mode          = s2_reg.mode;
        cmd_next.id            = s2_reg.id;
        cmd_next.vel_x         = s2_reg.vel_x;
        cmd_next.vel_y         = s2_reg.vel_y;
        cmd_next.vel_z         = s2_reg.vel_z;
        cmd_next.sample_enable = s2_reg.sample_enable;
        cmd_next.slot          = s2_reg.read_slot;
        cmd_next.v2            = V2_W'(sqx_reg) + V2_W'(sqy_reg) + V2_W'(sqz_reg);
        if (s2_reg.mode == MODE_BIN)
        begin
            cmd_next.cell_idx    = bin_cell;
            cmd_next.cell_number = 11'(bin_cell);
            cmd_next.in_grid     = 1'b1;
        end
        else
        begin
            cmd_next.cell_idx    = CELL_IDX_W'(s2_reg.read_cell);
            cmd_next.cell_number = s2_reg.read_cell;
            cmd_next.in_grid     = (32'(s2_reg.read_cell) < 32'(NCELLS));
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.mode          <= mode_t'(mode);
            s1_reg.pos_x         <= pos_x;
            s1_reg.pos_y         <= pos_y;
            s1_reg.pos_z         <= pos_z;
            s1_reg.vel_x         <= vel_x;
            s1_reg.vel_y         <= vel_y;
            s1_reg.vel_z         <= vel_z;
            s1_reg.id            <= particle_id;
            s1_reg.sample_enable <= sample_enable;
            s1_reg.read_cell     <= read_cell;
            s1_reg.read_slot     <= read_slot;
        end
        if (adv)
        begin
            s2_reg  <= s1_reg;
            px_reg  <= px_next;
            py_reg  <= py_next;
            pz_reg  <= pz_next;
            sqx_reg <= 40'(sqx_next);
            sqy_reg <= 40'(sqy_next);
            sqz_reg <= 40'(sqz_next);
            cmd_reg <= cmd_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pcb_back.sv =====
// Back end: owns the cell fill, member list and moment memories and carries out
// start, bin and read commands. Depends on pcb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcb_back import pcb_pkg::*; #(
    parameter int CELLS_X    = DEF_CELLS_X,
    parameter int CELLS_Y    = DEF_CELLS_Y,
    parameter int CELLS_Z    = DEF_CELLS_Z,
    parameter int LIST_DEPTH = DEF_LIST_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cmd_t q_head,
    input  wire logic q_empty,
    output logic      q_pop,
    input  wire logic out_full,
    output logic      out_push,
    output res_t      out_res,
    output logic      init_busy
);

    localparam int     NCELLS = CELLS_X * CELLS_Y * CELLS_Z;
    localparam int     CW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam longint MDEPTH = longint'(NCELLS) * longint'(LIST_DEPTH);
    localparam int     MW     = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
    localparam int     FW     = $clog2(LIST_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_LOOK  = 4'b0100,
        ST_PUSH  = 4'b1000
    } state_t;

    // memories
    logic [FW-1:0] fill_mem [NCELLS];
    mom_t          mom_mem  [NCELLS];
    logic [15:0]   memb_mem [MDEPTH];

    state_t        state_reg, state_next;
    logic          clear_all_reg, clear_all_next;
    logic [CW-1:0] sweep_reg, sweep_next;
    cmd_t          cur_reg, cur_next;
    logic          sampling_reg, sampling_next;
    logic [31:0]   steps_reg, steps_next;
    res_t          res_reg, res_next;
    logic [FW-1:0] fill_rd_reg;
    mom_t          mom_rd_reg;
    logic [15:0]   memb_rd_reg;

    logic          fill_we, mom_we, memb_we;
    logic [CW-1:0] fill_wa, mom_wa, rd_cell, cur_cell;
    logic [FW-1:0] fill_wd;
    mom_t          mom_wd, mom_upd;
    logic [MW-1:0] memb_wa, memb_ra;
    logic          list_full;

    assign init_busy = clear_all_reg;
    assign out_res   = res_reg;
    assign rd_cell   = CW'(q_head.cell_idx);
    assign cur_cell  = CW'(cur_reg.cell_idx);
    assign memb_ra   = MW'(rd_cell) * MW'(LIST_DEPTH) + MW'(q_head.slot);
    assign memb_wa   = MW'(cur_cell) * MW'(LIST_DEPTH) + MW'(fill_rd_reg);
    assign list_full = (32'(fill_rd_reg) >= 32'(LIST_DEPTH));

    // moment update of a sampled particle
    always_comb
    begin
        mom_upd.count = (mom_rd_reg.count == '1) ? mom_rd_reg.count : mom_rd_reg.count + 1'b1;
        mom_upd.vx    = sat_add_s(mom_rd_reg.vx, cur_reg.vel_x);
        mom_upd.vy    = sat_add_s(mom_rd_reg.vy, cur_reg.vel_y);
        mom_upd.vz    = sat_add_s(mom_rd_reg.vz, cur_reg.vel_z);
        mom_upd.v2    = sat_add_u(mom_rd_reg.v2, cur_reg.v2);
    end

    // command sequencer
    always_comb
    begin
        state_next     = state_reg;
        clear_all_next = clear_all_reg;
        sweep_next     = sweep_reg;
        cur_next       = cur_reg;
        sampling_next  = sampling_reg;
        steps_next     = steps_reg;
        res_next       = res_reg;
        q_pop          = 1'b0;
        out_push       = 1'b0;
        fill_we        = 1'b0;
        fill_wa        = sweep_reg;
        fill_wd        = '0;
        mom_we         = 1'b0;
        mom_wa         = sweep_reg;
        mom_wd         = '0;
        memb_we        = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                fill_we    = 1'b1;
                mom_we     = clear_all_reg;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == CW'(NCELLS - 1))
                begin
                    sweep_next     = '0;
                    clear_all_next = 1'b0;
                    state_next     = clear_all_reg ? ST_IDLE : ST_PUSH;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop                 = 1'b1;
                    cur_next              = q_head;
                    res_next              = '0;
                    res_next.sample_steps = steps_reg;
                    unique case (q_head.mode)
                        MODE_START:
                        begin
                            sampling_next = q_head.sample_enable;
                            if (q_head.sample_enable && (steps_reg != '1))
                                steps_next = steps_reg + 1'b1;
                            res_next.sample_steps = steps_next;
                            state_next            = ST_CLEAR;
                        end
                        MODE_BIN, MODE_READ:
                        begin
                            state_next = ST_LOOK;
                        end
                        MODE_NONE:
                        begin
                            res_next   = '0;
                            state_next = ST_PUSH;
                        end
                    endcase
                end
            end
            ST_LOOK:
            begin
                res_next.cell_number = cur_reg.cell_number;
                state_next           = ST_PUSH;
                if (cur_reg.mode == MODE_BIN)
                begin
                    res_next.sample_count = mom_rd_reg.count;
                    res_next.sum_vx       = mom_rd_reg.vx;
                    res_next.sum_vy       = mom_rd_reg.vy;
                    res_next.sum_vz       = mom_rd_reg.vz;
                    res_next.sum_v2       = mom_rd_reg.v2;
                    if (list_full)
                    begin
                        res_next.overflow   = 1'b1;
                        res_next.cell_count = 6'(fill_rd_reg);
                    end
                    else
                    begin
                        memb_we             = 1'b1;
                        fill_we             = 1'b1;
                        fill_wa             = cur_cell;
                        fill_wd             = fill_rd_reg + 1'b1;
                        res_next.slot       = 5'(fill_rd_reg);
                        res_next.list_entry = cur_reg.id;
                        res_next.cell_count = 6'(fill_wd);
                        if (sampling_reg)
                        begin
                            mom_we                = 1'b1;
                            mom_wa                = cur_cell;
                            mom_wd                = mom_upd;
                            res_next.sample_count = mom_upd.count;
                            res_next.sum_vx       = mom_upd.vx;
                            res_next.sum_vy       = mom_upd.vy;
                            res_next.sum_vz       = mom_upd.vz;
                            res_next.sum_v2       = mom_upd.v2;
                        end
                    end
                end
                else
                begin
                    res_next.slot = cur_reg.slot;
                    if (cur_reg.in_grid)
                    begin
                        res_next.cell_count   = 6'(fill_rd_reg);
                        res_next.sample_count = mom_rd_reg.count;
                        res_next.sum_vx       = mom_rd_reg.vx;
                        res_next.sum_vy       = mom_rd_reg.vy;
                        res_next.sum_vz       = mom_rd_reg.vz;
                        res_next.sum_v2       = mom_rd_reg.v2;
                        if (32'(cur_reg.slot) < 32'(fill_rd_reg))
                            res_next.list_entry = memb_rd_reg;
                    end
                end
            end
            ST_PUSH:
            begin
                if (!out_full)
                begin
                    out_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clear_all_reg <= 1'b1;
            sweep_reg     <= '0;
            sampling_reg  <= 1'b0;
            steps_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_all_reg <= clear_all_next;
            sweep_reg     <= sweep_next;
            sampling_reg  <= sampling_next;
            steps_reg     <= steps_next;
        end
    end

    // command and result payload
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        res_reg <= res_next;
    end

    // memory ports: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (fill_we)
            fill_mem[fill_wa] <= fill_wd;
        fill_rd_reg <= fill_mem[rd_cell];
    end

    always_ff @(posedge clk)
    begin
        if (mom_we)
            mom_mem[mom_wa] <= mom_wd;
        mom_rd_reg <= mom_mem[rd_cell];
    end

    always_ff @(posedge clk)
    begin
        if (memb_we)
            memb_mem[memb_wa] <= cur_reg.id;
        memb_rd_reg <= memb_mem[memb_ra];
    end

endmodule

`default_nettype wire

// ===== hdl/particle_cell_binning_sampler.sv =====
// Top level of the particle cell binning sampler: front classifier, command queue,
// back engine and result queue. Depends on pcb_pkg, pcb_front, pcb_fifo, pcb_back.
//
//   channel   handshake        payload
//   --------  ---------------  ---------------------------------------------------
//   item in   push / full      mode, pos_*, vel_*, particle_id, sample_enable,
//                              read_cell, read_slot
//   result    empty / pop      cell_number, slot, overflow, cell_count, list_entry,
//                              sample_count, sum_v*, sample_steps
//   config    cfg_we           cfg_index, cfg_data
//
// Bin and read beats pass 3 front stages, then the back-end steps memory read, update and
// hand-off to the result queue; the back end's read-modify-write sets the rate.
// A start beat sweeps the fill memory, one cell per cycle.
// After reset a clearing pass over every cell holds full high.
// A stalled result side backs up into the command queue, then full rises.
`timescale 1ns / 1ps
`default_nettype none

module particle_cell_binning_sampler import pcb_pkg::*; #(
    parameter int CELLS_X    = DEF_CELLS_X,
    parameter int CELLS_Y    = DEF_CELLS_Y,
    parameter int CELLS_Z    = DEF_CELLS_Z,
    parameter int LIST_DEPTH = DEF_LIST_DEPTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [1:0]           mode,
    input  wire logic signed [31:0]   pos_x,
    input  wire logic signed [31:0]   pos_y,
    input  wire logic signed [31:0]   pos_z,
    input  wire logic signed [19:0]   vel_x,
    input  wire logic signed [19:0]   vel_y,
    input  wire logic signed [19:0]   vel_z,
    input  wire logic [15:0]          particle_id,
    input  wire logic                 sample_enable,
    input  wire logic [10:0]          read_cell,
    input  wire logic [4:0]           read_slot,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [10:0]               cell_number,
    output logic [4:0]                slot,
    output logic                      overflow,
    output logic [5:0]                cell_count,
    output logic [15:0]               list_entry,
    output logic [31:0]               sample_count,
    output logic signed [63:0]        sum_vx,
    output logic signed [63:0]        sum_vy,
    output logic signed [63:0]        sum_vz,
    output logic [63:0]               sum_v2,
    output logic [31:0]               sample_steps,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    logic init_busy;
    logic q_full, q_push, q_empty, q_pop;
    cmd_t q_din, q_head;
    logic r_full, r_push;
    res_t r_din, r_head;

    // classify item beats
    pcb_front #(
        .CELLS_X (CELLS_X),
        .CELLS_Y (CELLS_Y),
        .CELLS_Z (CELLS_Z)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .mode          (mode),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .vel_x         (vel_x),
        .vel_y         (vel_y),
        .vel_z         (vel_z),
        .particle_id   (particle_id),
        .sample_enable (sample_enable),
        .read_cell     (read_cell),
        .read_slot     (read_slot),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .init_busy     (init_busy),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_din         (q_din)
    );

    // command queue between front and back
    pcb_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (2)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_din),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .empty   (q_empty)
    );

    // cell memories and command execution
    pcb_back #(
        .CELLS_X    (CELLS_X),
        .CELLS_Y    (CELLS_Y),
        .CELLS_Z    (CELLS_Z),
        .LIST_DEPTH (LIST_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_full  (r_full),
        .out_push  (r_push),
        .out_res   (r_din),
        .init_busy (init_busy)
    );

    // result queue
    pcb_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (r_push),
        .wr_data (r_din),
        .full    (r_full),
        .rd_en   (pop),
        .rd_data (r_head),
        .empty   (empty)
    );

    // result beat fields
    assign cell_number  = r_head.cell_number;
    assign slot         = r_head.slot;
    assign overflow     = r_head.overflow;
    assign cell_count   = r_head.cell_count;
    assign list_entry   = r_head.list_entry;
    assign sample_count = r_head.sample_count;
    assign sum_vx       = r_head.sum_vx;
    assign sum_vy       = r_head.sum_vy;
    assign sum_vz       = r_head.sum_vz;
    assign sum_v2       = r_head.sum_v2;
    assign sample_steps = r_head.sample_steps;

endmodule

`default_nettype wire

// ===== hdl/pcb_checker.sv =====
// Port-level checks of the particle cell binning sampler, bound to the top level.
// Depends on nothing but the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module pcb_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [10:0] cell_number,
    input wire logic [4:0]  slot,
    input wire logic        overflow,
    input wire logic [15:0] list_entry,
    input wire logic [63:0] sum_v2
);

    // a dropped particle takes no slot and stores no id
    a_overflow_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && overflow) |-> (slot == 5'd0) && (list_entry == 16'd0))
        else $error("overflow beat carries a slot or list entry");

    // clearing pass after reset: no item taken, no result shown as reset ends
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> full && empty)
        else $error("block not quiet at end of reset");

    // a waiting result beat holds until popped
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty && $stable(cell_number) && $stable(sum_v2))
        else $error("waiting result beat changed");

endmodule

bind particle_cell_binning_sampler pcb_checker u_pcb_checker (.*);

`default_nettype wire

// ===== dv/particle_cell_binning_sampler_chk.sv =====
// Checker for the particle cell binning sampler: watches the item, result and config
// ports, predicts each result and compares it field by field. Depends on pcb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module particle_cell_binning_sampler_chk import pcb_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire logic                 full,
    input  wire logic [1:0]           mode,
    input  wire logic signed [31:0]   pos_x,
    input  wire logic signed [31:0]   pos_y,
    input  wire logic signed [31:0]   pos_z,
    input  wire logic signed [19:0]   vel_x,
    input  wire logic signed [19:0]   vel_y,
    input  wire logic signed [19:0]   vel_z,
    input  wire logic [15:0]          particle_id,
    input  wire logic                 sample_enable,
    input  wire logic [10:0]          read_cell,
    input  wire logic [4:0]           read_slot,
    input  wire logic                 empty,
    input  wire logic                 pop,
    input  wire logic [10:0]          cell_number,
    input  wire logic [4:0]           slot,
    input  wire logic                 overflow,
    input  wire logic [5:0]           cell_count,
    input  wire logic [15:0]          list_entry,
    input  wire logic [31:0]          sample_count,
    input  wire logic signed [63:0]   sum_vx,
    input  wire logic signed [63:0]   sum_vy,
    input  wire logic signed [63:0]   sum_vz,
    input  wire logic [63:0]          sum_v2,
    input  wire logic [31:0]          sample_steps,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    output int                        errors,
    output int                        pending
);

    localparam int NX = DEF_CELLS_X;
    localparam int NY = DEF_CELLS_Y;
    localparam int NZ = DEF_CELLS_Z;
    localparam int DEPTH = DEF_LIST_DEPTH;
    localparam int NCELLS = NX * NY * NZ;

    // shadow of the block's state
    logic [31:0]        scale_x, scale_y, scale_z;
    logic [5:0]         fill [NCELLS];
    logic [15:0]        members [NCELLS * DEPTH];
    logic [31:0]        acc_n [NCELLS];
    logic signed [63:0] acc_vx [NCELLS];
    logic signed [63:0] acc_vy [NCELLS];
    logic signed [63:0] acc_vz [NCELLS];
    logic [63:0]        acc_v2 [NCELLS];
    logic [31:0]        steps;
    logic               sampling;

    res_t expected_results [$];

    // position times reciprocal width, truncated and clamped to the grid
    function automatic int unsigned grid_coord(logic signed [31:0] p, logic [31:0] inv,
                                               int unsigned cells);
        longint prod;
        longint unsigned hi;
        begin
            prod = longint'(p) * longint'({32'd0, inv});
            if (prod < 0)
                return 0;
            hi = longint'(prod) >>> 32;
            return (hi >= cells) ? cells - 1 : int'(hi);
        end
    endfunction

    function automatic logic signed [63:0] add_clip_s(logic signed [63:0] a,
                                                      logic signed [63:0] b);
        logic signed [64:0] s;
        begin
            s = $signed({a[63], a}) + $signed({b[63], b});
            if (s[64] != s[63])
                return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            return s[63:0];
        end
    endfunction

    function automatic logic [63:0] add_clip_u(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[64] ? {64{1'b1}} : s[63:0];
        end
    endfunction

    function automatic void show_cell(inout res_t r, input int c);
        r.cell_count   = fill[c];
        r.sample_count = acc_n[c];
        r.sum_vx       = acc_vx[c];
        r.sum_vy       = acc_vy[c];
        r.sum_vz       = acc_vz[c];
        r.sum_v2       = acc_v2[c];
    endfunction

    // next result from one accepted item, updating the shadow state
    function automatic res_t bin_and_sample();
        res_t r;
        int c, n, ix, iy, iz;
        longint vx, vy, vz;
        begin
            r = '0;
            case (mode_t'(mode))
                MODE_START: begin
                    for (int i = 0; i < NCELLS; i++)
                        fill[i] = '0;
                    sampling = sample_enable;
                    if (sampling && steps != 32'hFFFF_FFFF)
                        steps++;
                end
                MODE_BIN: begin
                    ix = grid_coord(pos_x, scale_x, NX);
                    iy = grid_coord(pos_y, scale_y, NY);
                    iz = grid_coord(pos_z, scale_z, NZ);
                    c  = (ix * NY + iy) * NZ + iz;
                    n  = fill[c];
                    r.cell_number = 11'(c);
                    if (n >= DEPTH) begin
                        r.overflow = 1'b1;
                    end else begin
                        members[c * DEPTH + n] = particle_id;
                        fill[c] = 6'(n + 1);
                        r.slot = 5'(n);
                        r.list_entry = particle_id;
                        if (sampling) begin
                            vx = vel_x;
                            vy = vel_y;
                            vz = vel_z;
                            if (acc_n[c] != 32'hFFFF_FFFF)
                                acc_n[c]++;
                            acc_vx[c] = add_clip_s(acc_vx[c], vx);
                            acc_vy[c] = add_clip_s(acc_vy[c], vy);
                            acc_vz[c] = add_clip_s(acc_vz[c], vz);
                            acc_v2[c] = add_clip_u(acc_v2[c], vx * vx + vy * vy + vz * vz);
                        end
                    end
                    show_cell(r, c);
                end
                MODE_READ: begin
                    c = read_cell;
                    r.cell_number = read_cell;
                    r.slot = read_slot;
                    if (c < NCELLS) begin
                        show_cell(r, c);
                        if (read_slot < fill[c])
                            r.list_entry = members[c * DEPTH + read_slot];
                    end
                end
                default: ;
            endcase
            if (mode_t'(mode) != MODE_NONE)
                r.sample_steps = steps;
            return r;
        end
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n) begin
        res_t want;
        if (!rst_n) begin
            scale_x  = INV_RESET;
            scale_y  = INV_RESET;
            scale_z  = INV_RESET;
            steps    = '0;
            sampling = 1'b0;
            errors   = 0;
            for (int i = 0; i < NCELLS; i++) begin
                fill[i]   = '0;
                acc_n[i]  = '0;
                acc_vx[i] = '0;
                acc_vy[i] = '0;
                acc_vz[i] = '0;
                acc_v2[i] = '0;
            end
            expected_results.delete();
        end else begin
            // config writes
            if (cfg_we) begin
                case (cfg_index)
                    CFG_INV_X: scale_x = cfg_data;
                    CFG_INV_Y: scale_y = cfg_data;
                    CFG_INV_Z: scale_z = cfg_data;
                    default: ;
                endcase
            end
            // result beat against the oldest prediction
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected, cell %0d",
                             $time, cell_number);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("cell_number", want.cell_number, cell_number);
                    check_field("slot", want.slot, slot);
                    check_field("overflow", want.overflow, overflow);
                    check_field("cell_count", want.cell_count, cell_count);
                    check_field("list_entry", want.list_entry, list_entry);
                    check_field("sample_count", want.sample_count, sample_count);
                    check_field("sum_vx", want.sum_vx, sum_vx);
                    check_field("sum_vy", want.sum_vy, sum_vy);
                    check_field("sum_vz", want.sum_vz, sum_vz);
                    check_field("sum_v2", want.sum_v2, sum_v2);
                    check_field("sample_steps", want.sample_steps, sample_steps);
                end
            end
            // item beat
            if (push && !full)
                expected_results.push_back(bin_and_sample());
        end
    end

endmodule

`default_nettype wire

// ===== dv/particle_cell_binning_sampler_tb.sv =====
// Testbench top for the particle cell binning sampler: clock, reset, item and config
// stimulus, result draining and verdict. Depends on pcb_pkg, the DUT and the checker.
`timescale 1ns / 1ps
`default_nettype none

module particle_cell_binning_sampler_tb import pcb_pkg::*;;

    localparam int CYCLE_LIMIT = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic [1:0] mode = MODE_NONE;
    logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic signed [19:0] vel_x = '0, vel_y = '0, vel_z = '0;
    logic [15:0] particle_id = '0;
    logic sample_enable = 1'b0;
    logic [10:0] read_cell = '0;
    logic [4:0] read_slot = '0;
    logic pop = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_INV_X;
    logic [31:0] cfg_data = '0;

    logic full, empty, overflow;
    logic [10:0] cell_number;
    logic [4:0] slot;
    logic [5:0] cell_count;
    logic [15:0] list_entry;
    logic [31:0] sample_count, sample_steps;
    logic signed [63:0] sum_vx, sum_vy, sum_vz;
    logic [63:0] sum_v2;

    int errors, pending;
    int items_in = 0;
    int results_out = 0;
    int cycles = 0;
    bit calm = 1'b0;
    bit hold_done = 1'b0;

    always #5 clk = ~clk;

    particle_cell_binning_sampler dut (.*);
    particle_cell_binning_sampler_chk chk (.*);

    // run limit
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** particle_cell_binning_sampler: FAILED **");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold-off once the block is busy
    initial begin
        int gap;
        gap = 0;
        forever begin
            @(posedge clk);
            if (pop && !empty)
                results_out++;
            if (!hold_done && items_in >= 30) begin
                hold_done = 1'b1;
                pop <= 1'b0;
                repeat (600) @(posedge clk);
            end else if (calm) begin
                pop <= 1'b1;
            end else if (gap > 0) begin
                gap--;
                pop <= 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
                gap = $urandom_range(1, 19) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // offer one item and hold it until the block takes it
    task automatic send_item(mode_t m, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [19:0] vx, logic [19:0] vy, logic [19:0] vz,
                             logic [15:0] id, logic se, logic [10:0] rc, logic [4:0] rs);
        mode <= m;
        pos_x <= px;
        pos_y <= py;
        pos_z <= pz;
        vel_x <= vx;
        vel_y <= vy;
        vel_z <= vz;
        particle_id <= id;
        sample_enable <= se;
        read_cell <= rc;
        read_slot <= rs;
        push <= 1'b1;
        do
            @(posedge clk);
        while (full);
        items_in++;
        // sender gap burst
        if (!calm && $urandom_range(0, 9) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_scales(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
        write_reg(CFG_INV_X, sx);
        write_reg(CFG_INV_Y, sy);
        write_reg(CFG_INV_Z, sz);
    endtask

    // let every outstanding result drain before touching config
    task automatic drain();
        push <= 1'b0;
        while (results_out != items_in)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_pos();
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        return $urandom_range(0, 19 << 16) - (1 << 16);
    endfunction

    function automatic logic [19:0] rand_vel();
        case ($urandom_range(0, 3))
            0: return 20'h7FFFF;
            1: return 20'h80000;
            default: return 20'($urandom);
        endcase
    endfunction

    task automatic random_items(int count, int tail);
        int pick;
        for (int i = 0; i < count; i++) begin
            if (count - i <= tail)
                calm = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 4)
                send_item(MODE_START, $urandom, $urandom, $urandom, 20'($urandom),
                          20'($urandom), 20'($urandom), 16'($urandom), 1'($urandom),
                          11'($urandom), 5'($urandom));
            else if (pick < 70)
                send_item(MODE_BIN, rand_pos(), rand_pos(), rand_pos(), rand_vel(),
                          rand_vel(), rand_vel(), 16'($urandom), 1'($urandom),
                          11'($urandom), 5'($urandom));
            else if (pick < 95)
                send_item(MODE_READ, $urandom, $urandom, $urandom, 20'($urandom),
                          20'($urandom), 20'($urandom), 16'($urandom), 1'($urandom),
                          ($urandom_range(0, 1) == 0) ? 11'($urandom_range(0, 3)) :
                          11'($urandom), 5'($urandom));
            else
                send_item(MODE_NONE, $urandom, $urandom, $urandom, 20'($urandom),
                          20'($urandom), 20'($urandom), 16'($urandom), 1'($urandom),
                          11'($urandom), 5'($urandom));
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every mode, reads past fill
        set_scales(INV_RESET, INV_RESET, INV_RESET);
        send_item(MODE_START, 0, 0, 0, 0, 0, 0, 0, 1'b1, 0, 0);
        send_item(MODE_BIN, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 16'hFFFF, 1'b0, 0, 0);
        send_item(MODE_BIN, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  20'h80000, 20'h80000, 20'h80000, 16'h0000, 1'b0, 0, 0);
        send_item(MODE_BIN, 0, 0, 0, 20'h80000, 20'h7FFFF, 20'h00001, 16'h1234, 1'b0, 0, 0);
        send_item(MODE_BIN, 32'h0003_8000, 32'h0000_FFFF, 32'h0007_FFFF,
                  20'hFFFFF, 0, 20'h12345, 16'hA5A5, 1'b0, 0, 0);
        send_item(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 1'b0, 11'd0, 5'd0);
        send_item(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 1'b0, 11'd0, 5'd1);
        send_item(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 1'b0, 11'd0, 5'd31);
        send_item(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 1'b0, 11'd2047, 5'd0);
        send_item(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 1'b0, 11'd2047, 5'd1);
        send_item(MODE_NONE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 16'hFFFF, 1'b1, 11'd5, 5'd3);
        send_item(MODE_START, 0, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0);
        send_item(MODE_BIN, 0, 0, 0, 20'h00100, 0, 0, 16'h0042, 1'b0, 0, 0);
        send_item(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 1'b0, 11'd0, 5'd0);
        drain();

        // every position lands in cell zero: the list fills and overflows
        set_scales(32'd0, 32'd0, 32'd0);
        send_item(MODE_START, 0, 0, 0, 0, 0, 0, 0, 1'b1, 0, 0);
        random_items(110, 0);
        drain();

        // widest scales pin every coordinate not below the axis cell count to the far edge
        set_scales(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_items(100, 0);
        drain();

        // uneven scales
        set_scales(32'd32768, 32'd131072, 32'd20000);
        random_items(100, 0);
        drain();

        // unit scales, last stretch with no idling
        set_scales(INV_RESET, INV_RESET, INV_RESET);
        random_items(120, 60);
        drain();

        if (errors == 0 && pending == 0)
            $display("** particle_cell_binning_sampler: PASSED **");
        else
            $display("** particle_cell_binning_sampler: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ===== particle_cell_binning_sampler.f =====
hdl/pcb_pkg.sv
hdl/pcb_fifo.sv
hdl/pcb_front.sv
hdl/pcb_back.sv
hdl/particle_cell_binning_sampler.sv
hdl/pcb_checker.sv
dv/particle_cell_binning_sampler_chk.sv
dv/particle_cell_binning_sampler_tb.sv
